// ===== hdl/rqme_pkg.sv =====
package rqme_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_WIDTH    = 8;
  localparam int ET_WIDTH    = 31;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STATUS_W    = 2;
  localparam int REQ_W       = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_FIND   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [ET_WIDTH-1:0] et;
  } entry_t;

endpackage

// ===== hdl/ready_queue_min_elapsed.sv =====
// Ready queue of up to 64 thread ids in arrival order, each kept with the
// elapsed time given at enqueue, in one single-port-write memory with a
// registered read. One request is handled at a time and gives one result.
// Enqueue, and any request on an empty queue, go straight to the result.
// Find-least-elapsed and a remove of an absent id walk the whole queue one
// entry a cycle. Dequeue and remove walk to the entry and then move every
// later entry down one slot, one memory write a cycle, so a removal walks
// or shifts past every entry wherever the entry stands. The memory's one
// read and one write port per cycle set this pace. in_stall is high from
// accept until the result has been taken. No clearing is needed after
// reset: data from a slot at or above the occupancy is never used.
module ready_queue_min_elapsed (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rqme_pkg::REQ_W-1:0]     req_type,
  input  logic [rqme_pkg::ID_WIDTH-1:0]  thread_id,
  input  logic [rqme_pkg::ET_WIDTH-1:0]  elapsed,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rqme_pkg::STATUS_W-1:0]  status,
  output logic [rqme_pkg::ID_WIDTH-1:0]  result_id,
  output logic [rqme_pkg::ET_WIDTH-1:0]  result_elapsed,
  output logic [rqme_pkg::CNT_W-1:0]     occupancy
);
  import rqme_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t              state;
  req_t                req;
  logic [ID_WIDTH-1:0] tid;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    pos;
  entry_t              best;
  entry_t              best_next;

  entry_t              mem [QUEUE_DEPTH];
  entry_t              rd_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  entry_t              mem_wdata;

  logic                accept;
  logic                full;
  logic                last;
  logic [CNT_W-1:0]    pos_inc1;
  logic [CNT_W-1:0]    pos_inc2;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt == CNT_W'(QUEUE_DEPTH));
  assign pos_inc1 = CNT_W'(pos + 1'b1);
  assign pos_inc2 = CNT_W'(pos + 2'd2);
  assign last     = (pos_inc1 == cnt);

  // running minimum; strict compare keeps the earliest entry on ties
  always_comb begin
    if (pos == '0 || rd_data.et < best.et) begin
      best_next = rd_data;
    end else begin
      best_next = best;
    end
  end

  // memory port control: read data is always the entry at pos while
  // scanning, and the entry at pos + 1 while shifting
  always_comb begin
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_waddr = cnt[ADDR_W-1:0];
    mem_wdata = '{id: thread_id, et: elapsed};
    case (state)
      S_IDLE: begin
        if (accept && req_type == REQ_ENQ && !full) begin
          mem_we = 1'b1;
        end
      end
      S_SCAN: begin
        rd_addr = pos_inc1[ADDR_W-1:0];
      end
      S_SHIFT: begin
        rd_addr   = pos_inc2[ADDR_W-1:0];
        mem_we    = !last;
        mem_waddr = pos[ADDR_W-1:0];
        mem_wdata = rd_data;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            req <= req_t'(req_type);
            tid <= thread_id;
            pos <= '0;
            if (req_type == REQ_ENQ) begin
              state     <= S_DONE;
              out_valid <= 1'b1;
              if (full) begin
                status         <= ST_FULL;
                result_id      <= '0;
                result_elapsed <= '0;
                occupancy      <= cnt;
              end else begin
                status         <= ST_OK;
                result_id      <= thread_id;
                result_elapsed <= elapsed;
                occupancy      <= CNT_W'(cnt + 1'b1);
                cnt            <= CNT_W'(cnt + 1'b1);
              end
            end else if (cnt == '0) begin
              state          <= S_DONE;
              out_valid      <= 1'b1;
              status         <= ST_MISS;
              result_id      <= '0;
              result_elapsed <= '0;
              occupancy      <= cnt;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (req == REQ_DEQ || (req == REQ_REMOVE && rd_data.id == tid)) begin
            status         <= ST_OK;
            result_id      <= rd_data.id;
            result_elapsed <= rd_data.et;
            state          <= S_SHIFT;
          end else if (req == REQ_FIND) begin
            best <= best_next;
            if (last) begin
              status         <= ST_OK;
              result_id      <= best_next.id;
              result_elapsed <= best_next.et;
              occupancy      <= cnt;
              out_valid      <= 1'b1;
              state          <= S_DONE;
            end else begin
              pos <= pos_inc1;
            end
          end else if (last) begin
            status         <= ST_MISS;
            result_id      <= '0;
            result_elapsed <= '0;
            occupancy      <= cnt;
            out_valid      <= 1'b1;
            state          <= S_DONE;
          end else begin
            pos <= pos_inc1;
          end
        end
        S_SHIFT: begin
          if (last) begin
            cnt       <= CNT_W'(cnt - 1'b1);
            occupancy <= CNT_W'(cnt - 1'b1);
            out_valid <= 1'b1;
            state     <= S_DONE;
          end else begin
            pos <= pos_inc1;
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
